// File: design/aadd_pkg.sv
// Package: widths, codes, payload type and constant-divide helpers for the axis decimal display.
`default_nettype none
package aadd_pkg;

  localparam int SAMPLE_BITS = 13;
  localparam int PROD_W      = SAMPLE_BITS + 6;
  localparam int RECIP_W     = 18;

  localparam logic       MODE_SAMPLE = 1'b0;
  localparam logic       MODE_BUTTON = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [RECIP_W-1:0] RECIP_1E1 = 18'd209716;
  localparam int                 SHIFT_1E1 = 21;
  localparam logic [RECIP_W-1:0] RECIP_1E2 = 18'd167773;
  localparam int                 SHIFT_1E2 = 24;
  localparam logic [RECIP_W-1:0] RECIP_1E3 = 18'd134218;
  localparam int                 SHIFT_1E3 = 27;
  localparam logic [RECIP_W-1:0] RECIP_1E4 = 18'd214749;
  localparam int                 SHIFT_1E4 = 31;
  localparam logic [PROD_W-1:0]  LIMIT_1E5 = PROD_W'(100000);

  typedef struct packed {
    logic                   negative;
    logic [SAMPLE_BITS-1:0] mag;
    logic [1:0]             axis;
  } sample_t;

  function automatic logic [PROD_W-1:0] div_const(
    input logic [PROD_W-1:0]  p,
    input logic [RECIP_W-1:0] recip,
    input int                 shift
  );
    logic [PROD_W+RECIP_W-1:0] prod;
    logic [PROD_W+RECIP_W-1:0] shifted;
    prod    = {{RECIP_W{1'b0}}, p} * {{PROD_W{1'b0}}, recip};
    shifted = prod >> shift;
    return shifted[PROD_W-1:0];
  endfunction

  function automatic logic [3:0] digit_of(
    input logic [PROD_W-1:0] q_lo,
    input logic [PROD_W-1:0] q_hi
  );
    logic [PROD_W-1:0] diff;
    diff = q_lo - (q_hi << 3) - (q_hi << 1);
    return diff[3:0];
  endfunction

endpackage
`default_nettype wire

// File: design/accel_axis_decimal_display_top.sv
// Top level: accelerometer axis decimal display.
//
// Input channel (in_valid/in_ready) carries one beat per event. mode 0 is a
// sample tick with raw_x, raw_y, raw_z; mode 1 is a button press that steps
// the axis selector X -> Y -> Z -> X and produces no result beat.
// Output channel (out_valid/out_ready) carries one beat per sample tick:
// negative flag, five decimal digits of trunc(39*|v|/10) in milli-g, and
// the axis shown.
// A sample is held first in the input register, then in the result
// register, and out_valid rises when the result register takes it.
// Throughput: one beat per cycle while out_ready stays high; the scale
// and digit split is a single combinational pass of parallel constant
// multiplies between the two registers.
// Reset: clears both valid flags and sets the selector to X.
// Stall: with out_ready low, the result register holds and the input
// register can still take one more sample; a button press is taken
// whenever in_ready is high.
`default_nettype none
module accel_axis_decimal_display_top import aadd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               mode,
  input  wire logic signed [12:0] raw_x,
  input  wire logic signed [12:0] raw_y,
  input  wire logic signed [12:0] raw_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    negative,
  output logic [3:0]              digit_units,
  output logic [3:0]              digit_tens,
  output logic [3:0]              digit_hundreds,
  output logic [3:0]              digit_thousands,
  output logic [3:0]              digit_ten_thousands,
  output logic [1:0]              axis_shown
);

  logic       s_valid;
  logic       s_ready;
  sample_t    s_data;
  logic [1:0] axis_select;

  aadd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .raw_x       (raw_x),
    .raw_y       (raw_y),
    .raw_z       (raw_z),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .axis_select (axis_select)
  );

  aadd_digits u_digits (
    .clk                 (clk),
    .rst                 (rst),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .s_data              (s_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .negative            (negative),
    .digit_units         (digit_units),
    .digit_tens          (digit_tens),
    .digit_hundreds      (digit_hundreds),
    .digit_thousands     (digit_thousands),
    .digit_ten_thousands (digit_ten_thousands),
    .axis_shown          (axis_shown)
  );

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    axis_select != 2'd3)
    else $error("axis selector left its range");

  a_axis_step: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode == MODE_BUTTON) |=>
      (axis_select == (($past(axis_select) == AXIS_Z) ? AXIS_X : $past(axis_select) + 2'd1)))
    else $error("button press did not step the axis selector");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_units <= 4'd9 && digit_tens <= 4'd9 && digit_hundreds <= 4'd9 &&
                   digit_thousands <= 4'd9 && digit_ten_thousands <= 4'd1))
    else $error("decimal digit out of range");

  a_neg_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && negative) |-> (digit_units != 4'd0 || digit_tens != 4'd0 ||
                                 digit_hundreds != 4'd0 || digit_thousands != 4'd0 ||
                                 digit_ten_thousands != 4'd0))
    else $error("negative flag on a zero magnitude");

endmodule
`default_nettype wire

// File: design/aadd_front.sv
// Input stage: axis selector, axis mux, sign and magnitude register.
`default_nettype none
module aadd_front import aadd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   mode,
  input  wire logic signed [12:0]     raw_x,
  input  wire logic signed [12:0]     raw_y,
  input  wire logic signed [12:0]     raw_z,
  output logic                        s_valid,
  input  wire logic                   s_ready,
  output sample_t                     s_data,
  output logic [1:0]                  axis_select
);

  logic [12:0]            raw_sel;
  logic [SAMPLE_BITS-1:0] v;
  logic                   v_neg;
  logic [SAMPLE_BITS-1:0] v_mag;
  logic [1:0]             axis_select_next;
  logic                   accept;

  assign in_ready = !s_valid || s_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (axis_select)
      AXIS_X:  raw_sel = raw_x;
      AXIS_Y:  raw_sel = raw_y;
      default: raw_sel = raw_z;
    endcase
  end

  assign v                = raw_sel[SAMPLE_BITS-1:0];
  assign v_neg            = v[SAMPLE_BITS-1];
  assign v_mag            = v_neg ? (~v + SAMPLE_BITS'(1)) : v;
  assign axis_select_next = (axis_select >= AXIS_Z) ? AXIS_X : (axis_select + 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_select <= AXIS_X;
      s_valid     <= 1'b0;
    end else if (accept) begin
      if (mode == MODE_BUTTON) begin
        axis_select <= axis_select_next;
        s_valid     <= 1'b0;
      end else begin
        s_valid     <= 1'b1;
      end
    end else if (s_ready) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mode == MODE_SAMPLE) begin
      s_data.negative <= v_neg;
      s_data.mag      <= v_mag;
      s_data.axis     <= axis_select;
    end
  end

endmodule
`default_nettype wire

// File: design/aadd_digits.sv
// Result stage: scale to milli-g, split into decimal digits, result register.
`default_nettype none
module aadd_digits import aadd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_valid,
  output logic       s_ready,
  input  wire sample_t s_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic       negative,
  output logic [3:0] digit_units,
  output logic [3:0] digit_tens,
  output logic [3:0] digit_hundreds,
  output logic [3:0] digit_thousands,
  output logic [3:0] digit_ten_thousands,
  output logic [1:0] axis_shown
);

  logic [PROD_W-1:0] mag_ext;
  logic [PROD_W-1:0] p;
  logic [PROD_W-1:0] q1;
  logic [PROD_W-1:0] q2;
  logic [PROD_W-1:0] q3;
  logic [PROD_W-1:0] q4;
  logic [PROD_W-1:0] q5;
  logic              accept;

  assign s_ready = !out_valid || out_ready;
  assign accept  = s_valid && s_ready;

  // p = 39 * magnitude; q_k = p / 10^k
  assign mag_ext = PROD_W'(s_data.mag);
  assign p       = (mag_ext << 5) + (mag_ext << 2) + (mag_ext << 1) + mag_ext;
  assign q1      = div_const(p, RECIP_1E1, SHIFT_1E1);
  assign q2      = div_const(p, RECIP_1E2, SHIFT_1E2);
  assign q3      = div_const(p, RECIP_1E3, SHIFT_1E3);
  assign q4      = div_const(p, RECIP_1E4, SHIFT_1E4);
  assign q5      = (p >= LIMIT_1E5) ? PROD_W'(1) : PROD_W'(0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      negative            <= s_data.negative;
      digit_units         <= digit_of(q1, q2);
      digit_tens          <= digit_of(q2, q3);
      digit_hundreds      <= digit_of(q3, q4);
      digit_thousands     <= digit_of(q4, q5);
      digit_ten_thousands <= q5[3:0];
      axis_shown          <= s_data.axis;
    end
  end

endmodule
`default_nettype wire
